// ----- src/pbb_pkg.sv -----
// Shared constants, register codes and command/result types for the page bitmap blit unit.
// No dependencies; the other files that use this package refer to it by scoped names.
package pbb_pkg;

  // Frame store geometry.
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_PAGES   = 8;
  localparam int PAGE_BITS   = 8;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAGE_IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SHIFT_W     = $clog2(PAGE_BITS);
  localparam int WIDTH_W     = $clog2(MAX_COLUMNS) + 1;
  localparam int PAGES_W     = $clog2(MAX_PAGES) + 1;
  localparam int PROD_W      = 2 * ADDR_W;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] CFG_SCREEN_PAGES = 2'd1;
  localparam logic [1:0] CFG_PLACE_X      = 2'd2;
  localparam logic [1:0] CFG_PLACE_Y      = 2'd3;

  // Request function codes.
  localparam logic FUNC_BLIT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic              is_read;
    logic              skip;
    logic              has_bot;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] bot_addr;
    logic [7:0]        top_bits;
    logic [7:0]        bot_bits;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       skipped;
  } result_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ----- src/page_bitmap_blit_unit.sv -----
// Top level of the page bitmap blit unit: front end, back end and the command queue between.
// Depends on pbb_pkg, pbb_front, pbb_back.
//
// After reset the unit clears its 1024-byte frame store, one byte per cycle, and holds full high
// until it is done; configuration writes are taken at any time. Each request then gives one
// result. A read passes a read-wait step, a blit that fits in one page a top read-modify-write
// step, one that straddles two pages a top and a bottom step, and a rejected blit is answered
// as it is taken; the single sequencer on the frame store does these steps one request at a
// time, and a two-entry queue on each side lets requests and results move while it works.
module page_bitmap_blit_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [7:0] pixel_byte,
  input  logic [7:0] column_index,
  input  logic [7:0] page_row,
  input  logic [9:0] read_address,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data,
  output logic       skipped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic                  cmd_valid;
  logic                  cmd_take;
  pbb_pkg::cmd_t         cmd;
  pbb_pkg::back_status_t back_status;

  // Request classification and configuration.
  pbb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .pixel_byte   (pixel_byte),
    .column_index (column_index),
    .page_row     (page_row),
    .read_address (read_address),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .back_status  (back_status)
  );

  // Frame store access and results.
  pbb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .back_status (back_status),
    .empty       (empty),
    .pop         (pop),
    .read_data   (read_data),
    .skipped     (skipped)
  );

endmodule

// ----- src/pbb_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pbb_front.sv -----
// Front end: configuration registers, request classification and a two-entry command queue.
// Depends on pbb_pkg.
module pbb_front (
  input  logic                 clk,
  input  logic                 rst,
  // Request side
  input  logic                 push,
  output logic                 full,
  input  logic                 func,
  input  logic [7:0]           pixel_byte,
  input  logic [7:0]           column_index,
  input  logic [7:0]           page_row,
  input  logic [9:0]           read_address,
  // Configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  // Command queue to the back end
  output logic                 cmd_valid,
  output pbb_pkg::cmd_t        cmd,
  input  logic                 cmd_take,
  input  pbb_pkg::back_status_t back_status
);

  logic [7:0] screen_width;
  logic [3:0] screen_pages;
  logic [7:0] place_x;
  logic [7:0] place_y;

  logic [pbb_pkg::WIDTH_W-1:0]    w_eff;
  logic [pbb_pkg::PAGES_W-1:0]    p_eff;
  logic [7:0]                     x;
  logic [pbb_pkg::SHIFT_W-1:0]    s;
  logic [8:0]                     top_page;
  logic [8:0]                     bot_page;
  logic [pbb_pkg::PROD_W-1:0]     top_sum;
  logic [2*pbb_pkg::PAGE_BITS-1:0] shifted;
  pbb_pkg::cmd_t                  new_cmd;

  pbb_pkg::cmd_t q_mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          accept;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 8'd128;
      screen_pages <= 4'd8;
      place_x      <= 8'd0;
      place_y      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbb_pkg::CFG_SCREEN_WIDTH: screen_width <= cfg_data;
        pbb_pkg::CFG_SCREEN_PAGES: screen_pages <= cfg_data[3:0];
        pbb_pkg::CFG_PLACE_X:      place_x      <= cfg_data;
        pbb_pkg::CFG_PLACE_Y:      place_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry saturates at the store size.
  always_comb begin
    if ({1'b0, screen_width} > 9'(pbb_pkg::MAX_COLUMNS)) begin
      w_eff = pbb_pkg::WIDTH_W'(pbb_pkg::MAX_COLUMNS);
    end else begin
      w_eff = pbb_pkg::WIDTH_W'(screen_width);
    end
    if ({1'b0, screen_pages} > 5'(pbb_pkg::MAX_PAGES)) begin
      p_eff = pbb_pkg::PAGES_W'(pbb_pkg::MAX_PAGES);
    end else begin
      p_eff = pbb_pkg::PAGES_W'(screen_pages);
    end
  end

  // Classify the request: screen column, page pair, bit shift and range check.
  always_comb begin
    x        = place_x + column_index;
    s        = place_y[pbb_pkg::SHIFT_W-1:0];
    top_page = {1'b0, page_row} + 9'(place_y >> pbb_pkg::SHIFT_W);
    bot_page = {1'b0, page_row}
             + 9'((9'(place_y) + 9'(pbb_pkg::PAGE_BITS - 1)) >> pbb_pkg::SHIFT_W);
    top_sum  = pbb_pkg::PROD_W'(top_page[pbb_pkg::PAGE_IDX_W-1:0]) * pbb_pkg::PROD_W'(w_eff)
             + pbb_pkg::PROD_W'(x);
    shifted  = (2*pbb_pkg::PAGE_BITS)'(pixel_byte) << s;

    new_cmd.is_read  = (func == pbb_pkg::FUNC_READ);
    new_cmd.skip     = (func == pbb_pkg::FUNC_BLIT)
                     && ((9'(x) >= 9'(w_eff)) || (bot_page >= 9'(p_eff)));
    new_cmd.has_bot  = (s != '0);
    new_cmd.top_addr = (func == pbb_pkg::FUNC_READ) ? read_address
                                                   : top_sum[pbb_pkg::ADDR_W-1:0];
    new_cmd.bot_addr = pbb_pkg::ADDR_W'(top_sum + pbb_pkg::PROD_W'(w_eff));
    new_cmd.top_bits = shifted[pbb_pkg::PAGE_BITS-1:0];
    new_cmd.bot_bits = shifted[2*pbb_pkg::PAGE_BITS-1:pbb_pkg::PAGE_BITS];
  end

  // No request is taken while the back end clears the store.
  assign full   = (count == 2'd2) || back_status.clearing;
  assign accept = push && !full;

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(cmd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q_mem[rd_ptr];

endmodule

// ----- src/pbb_back.sv -----
// Back end: store clearing after reset, read-modify-write sequencing and the result queue.
// Depends on pbb_pkg and pbb_ram.
module pbb_back (
  input  logic                  clk,
  input  logic                  rst,
  // Command queue from the front end
  input  logic                  cmd_valid,
  input  pbb_pkg::cmd_t         cmd,
  output logic                  cmd_take,
  output pbb_pkg::back_status_t back_status,
  // Result side
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            read_data,
  output logic                  skipped
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW_TOP,
    ST_RMW_BOT,
    ST_RD_WAIT
  } state_t;

  state_t                       state;
  pbb_pkg::cmd_t                cur;
  logic [pbb_pkg::ADDR_W-1:0]   clr_addr;

  logic                         ram_we;
  logic [pbb_pkg::ADDR_W-1:0]   ram_waddr;
  logic [7:0]                   ram_wdata;
  logic [pbb_pkg::ADDR_W-1:0]   ram_raddr;
  logic [7:0]                   ram_rdata;

  logic                         res_push;
  pbb_pkg::result_t             res_data;
  pbb_pkg::result_t             res_mem [2];
  logic                         res_wr_ptr;
  logic                         res_rd_ptr;
  logic [1:0]                   res_count;
  logic                         res_full;
  logic                         res_pop;

  pbb_ram #(
    .WIDTH (8),
    .DEPTH (pbb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_full  = (res_count == 2'd2);
  assign res_pop   = pop && !empty;
  assign cmd_take  = (state == ST_IDLE) && cmd_valid && !res_full;
  assign back_status.clearing = (state == ST_CLEAR);

  // Memory port and result push for the current step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.top_addr;
    ram_wdata = ram_rdata | cur.top_bits;
    ram_raddr = cmd.top_addr;
    res_push  = 1'b0;
    res_data  = '{read_data: 8'd0, skipped: 1'b0};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 8'd0;
      end
      ST_IDLE: begin
        if (cmd_take && !cmd.is_read && cmd.skip) begin
          res_push = 1'b1;
          res_data = '{read_data: 8'd0, skipped: 1'b1};
        end
      end
      ST_RMW_TOP: begin
        ram_we    = 1'b1;
        ram_raddr = cur.bot_addr;
        res_push  = !cur.has_bot;
      end
      ST_RMW_BOT: begin
        ram_we    = 1'b1;
        ram_waddr = cur.bot_addr;
        ram_wdata = ram_rdata | cur.bot_bits;
        res_push  = 1'b1;
      end
      ST_RD_WAIT: begin
        res_push = 1'b1;
        res_data = '{read_data: ram_rdata, skipped: 1'b0};
      end
      default: ;
    endcase
  end

  // Sequencer: clearing pass, then one request at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == pbb_pkg::ADDR_W'(pbb_pkg::STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_take) begin
            cur <= cmd;
            if (cmd.is_read) begin
              state <= ST_RD_WAIT;
            end else if (!cmd.skip) begin
              state <= ST_RMW_TOP;
            end
          end
        end
        ST_RMW_TOP: begin
          state <= cur.has_bot ? ST_RMW_BOT : ST_IDLE;
        end
        ST_RMW_BOT: state <= ST_IDLE;
        ST_RD_WAIT: state <= ST_IDLE;
        default:    state <= ST_IDLE;
      endcase
    end
  end

  // Two-entry result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_pop) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      res_count <= res_count + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr_ptr] <= res_data;
    end
  end

  assign empty     = (res_count == 2'd0);
  assign read_data = res_mem[res_rd_ptr].read_data;
  assign skipped   = res_mem[res_rd_ptr].skipped;

endmodule

// ----- src/pbb_checker.sv -----
// Port-level checker for the page bitmap blit unit, bound to the top level.
// Depends only on the top level's ports.
module pbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] read_data,
  input logic       skipped
);

  logic [3:0] outstanding;

  // Requests taken whose results have not yet been popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 4'd0;
    end else begin
      outstanding <= outstanding + 4'(push && !full) - 4'(pop && !empty);
    end
  end

  // The store is being cleared right after reset, so no request can enter.
  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  // No result waits right after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A result is only shown when a request is owed one.
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (outstanding != 4'd0))
    else $error("result shown with no request outstanding");

  // A result that is not popped stays in place.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(read_data) && $stable(skipped)))
    else $error("waiting result changed");

endmodule

bind page_bitmap_blit_unit pbb_checker u_pbb_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .read_data (read_data),
  .skipped   (skipped)
);

// ----- dv/page_bitmap_blit_unit_tb.sv -----
// Self-checking testbench for page_bitmap_blit_unit: directed and random blit and read requests,
// checked against a shadow copy of the frame store kept in the testbench.
// Depends on pbb_pkg and the RTL of page_bitmap_blit_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       func = pbb_pkg::FUNC_BLIT;
  logic [7:0] pixel_byte = '0;
  logic [7:0] column_index = '0;
  logic [7:0] page_row = '0;
  logic [9:0] read_address = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] read_data;
  logic       skipped;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = pbb_pkg::CFG_SCREEN_WIDTH;
  logic [7:0] cfg_data = '0;

  // Shadow of the frame store and of the registers.
  logic [7:0] frame_copy [pbb_pkg::STORE_DEPTH];
  logic [7:0] shadow_width = 8'd128;
  logic [3:0] shadow_pages = 4'd8;
  logic [7:0] shadow_place_x = 8'd0;
  logic [7:0] shadow_place_y = 8'd0;

  pbb_pkg::result_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  page_bitmap_blit_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .pixel_byte(pixel_byte), .column_index(column_index), .page_row(page_row),
    .read_address(read_address), .empty(empty), .pop(pop), .read_data(read_data),
    .skipped(skipped), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (frame_copy[i]) frame_copy[i] = '0;
  end

  // Effective geometry: oversized width and page count saturate at the store size.
  function automatic int eff_width();
    return (shadow_width > pbb_pkg::MAX_COLUMNS) ? pbb_pkg::MAX_COLUMNS : int'(shadow_width);
  endfunction

  function automatic int eff_pages();
    return (shadow_pages > pbb_pkg::MAX_PAGES) ? pbb_pkg::MAX_PAGES : int'(shadow_pages);
  endfunction

  // Applies one request to the shadow store and returns the result it should give.
  function automatic pbb_pkg::result_t blit_or_read(logic f, logic [7:0] pix, logic [7:0] col,
                                                    logic [7:0] prow, logic [9:0] raddr);
    pbb_pkg::result_t r;
    logic [7:0] x;
    logic [7:0] up_bits;
    logic [7:0] down_bits;
    int         w, p, s, top, bot;
    r = '0;
    if (f == pbb_pkg::FUNC_READ) begin
      r.read_data = (int'(raddr) < pbb_pkg::STORE_DEPTH) ? frame_copy[raddr] : 8'd0;
      return r;
    end
    w = eff_width();
    p = eff_pages();
    x = shadow_place_x + col;
    s = int'(shadow_place_y) % pbb_pkg::PAGE_BITS;
    top = int'(prow) + int'(shadow_place_y) / pbb_pkg::PAGE_BITS;
    bot = int'(prow) + (int'(shadow_place_y) + pbb_pkg::PAGE_BITS - 1) / pbb_pkg::PAGE_BITS;
    // Off-screen column or bottom page past the screen's pages: nothing is written.
    if (int'(x) >= w || bot * w + int'(x) >= w * p) begin
      r.skipped = 1'b1;
      return r;
    end
    up_bits = pix << s;
    frame_copy[top * w + int'(x)] = frame_copy[top * w + int'(x)] | up_bits;
    if (s != 0) begin
      down_bits = pix >> (pbb_pkg::PAGE_BITS - s);
      frame_copy[bot * w + int'(x)] = frame_copy[bot * w + int'(x)] | down_bits;
    end
    return r;
  endfunction

  // Sends one request; the expected result is recorded when the request is accepted.
  task automatic send_request(logic f, logic [7:0] pix, logic [7:0] col, logic [7:0] prow,
                              logic [9:0] raddr);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    func <= f;
    pixel_byte <= pix;
    column_index <= col;
    page_row <= prow;
    read_address <= raddr;
    do @(posedge clk); while (full);
    expected_results.push_back(blit_or_read(f, pix, col, prow, raddr));
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes one register once the unit is idle.
  task automatic write_register(logic [1:0] idx, logic [7:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pbb_pkg::CFG_SCREEN_WIDTH: shadow_width = val;
      pbb_pkg::CFG_SCREEN_PAGES: shadow_pages = val[3:0];
      pbb_pkg::CFG_PLACE_X:      shadow_place_x = val;
      default:                   shadow_place_y = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: pop is drawn afresh every cycle from the current idle share.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    pbb_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_data %02h skipped %0b",
                 $time, read_data, skipped);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (read_data !== want.read_data) begin
          $display("%0t: read_data expected %02h actual %02h", $time, want.read_data, read_data);
          errors++;
        end
        if (skipped !== want.skipped) begin
          $display("%0t: skipped expected %0b actual %0b", $time, want.skipped, skipped);
          errors++;
        end
      end
    end
  end

  // Corners of the fields, the shift across two pages, the column wrap, rejection,
  // saturated and zero geometry, and reads that ignore the geometry.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd0);
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd1023);
    send_request(pbb_pkg::FUNC_BLIT, 8'hFF, 8'd0, 8'd0, 10'd1023);
    send_request(pbb_pkg::FUNC_READ, 8'h00, 8'd0, 8'd0, 10'd0);
    send_request(pbb_pkg::FUNC_BLIT, 8'h81, 8'd127, 8'd7, 10'd0);
    send_request(pbb_pkg::FUNC_READ, 8'hFF, 8'hFF, 8'hFF, 10'd1023);
    // Column equal to the width is off screen.
    send_request(pbb_pkg::FUNC_BLIT, 8'h3C, 8'd128, 8'd0, 10'($urandom));
    send_request(pbb_pkg::FUNC_BLIT, 8'h3C, 8'd255, 8'd255, 10'($urandom));
    // Bottom page past the store.
    send_request(pbb_pkg::FUNC_BLIT, 8'h3C, 8'd5, 8'd8, 10'($urandom));

    // Offset by three rows: the byte straddles two pages; the column offset wraps.
    write_register(pbb_pkg::CFG_PLACE_X, 8'd255);
    write_register(pbb_pkg::CFG_PLACE_Y, 8'd3);
    send_request(pbb_pkg::FUNC_BLIT, 8'hA5, 8'd2, 8'd1, 10'($urandom));
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd129);
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd257);
    send_request(pbb_pkg::FUNC_BLIT, 8'h01, 8'd0, 8'd6, 10'($urandom));
    send_request(pbb_pkg::FUNC_BLIT, 8'hF0, 8'd1, 8'd6, 10'($urandom));
    send_request(pbb_pkg::FUNC_BLIT, 8'hF0, 8'd1, 8'd7, 10'($urandom));

    // Oversized geometry saturates.
    write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'd255);
    write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'd15);
    send_request(pbb_pkg::FUNC_BLIT, 8'h80, 8'd128, 8'd6, 10'($urandom));
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd1023);

    // Zero geometry skips every blit, while reads still see the raw store.
    write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'd0);
    send_request(pbb_pkg::FUNC_BLIT, 8'hFF, 8'd1, 8'd0, 10'($urandom));
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd0);
    write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'd1);
    write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'd0);
    send_request(pbb_pkg::FUNC_BLIT, 8'hFF, 8'd1, 8'd0, 10'($urandom));

    // Smallest screen: one column, one page.
    write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'd1);
    write_register(pbb_pkg::CFG_PLACE_Y, 8'd0);
    send_request(pbb_pkg::FUNC_BLIT, 8'h5A, 8'd1, 8'd0, 10'($urandom));
    send_request(pbb_pkg::FUNC_BLIT, 8'h5A, 8'd2, 8'd0, 10'($urandom));
    send_request(pbb_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), 10'd0);
  endtask

  // Random traffic under several geometries; most blits are aimed on screen and use
  // sparse bytes so that the store does not fill up.
  task automatic test_random_traffic(int send_pct, int recv_pct, int per_setting);
    int         w, p, lift, roll;
    logic [7:0] pix, col, prow;
    logic [9:0] raddr;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      case ($urandom_range(11))
        0:       write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'd0);
        1:       write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'd1);
        2, 3:    write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'd128);
        4:       write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'($urandom_range(129, 255)));
        default: write_register(pbb_pkg::CFG_SCREEN_WIDTH, 8'($urandom_range(1, 128)));
      endcase
      case ($urandom_range(11))
        0:       write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'd0);
        1:       write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'd1);
        2, 3:    write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'd8);
        4:       write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'($urandom_range(9, 15)));
        default: write_register(pbb_pkg::CFG_SCREEN_PAGES, 8'($urandom_range(1, 8)));
      endcase
      case ($urandom_range(5))
        0:       write_register(pbb_pkg::CFG_PLACE_X, 8'd0);
        1:       write_register(pbb_pkg::CFG_PLACE_X, 8'd255);
        default: write_register(pbb_pkg::CFG_PLACE_X, 8'($urandom));
      endcase
      case ($urandom_range(7))
        0:       write_register(pbb_pkg::CFG_PLACE_Y, 8'd255);
        1:       write_register(pbb_pkg::CFG_PLACE_Y, 8'($urandom));
        default: write_register(pbb_pkg::CFG_PLACE_Y, 8'($urandom_range(0, 31)));
      endcase
      w = eff_width();
      p = eff_pages();
      lift = (int'(shadow_place_y) + pbb_pkg::PAGE_BITS - 1) / pbb_pkg::PAGE_BITS;
      repeat (per_setting) begin
        roll = $urandom_range(99);
        pix = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(7));
        col = 8'($urandom);
        prow = 8'($urandom);
        raddr = 10'($urandom);
        if (roll < 55) begin
          // Blit aimed inside the screen where the geometry allows it.
          if (w > 0 && lift < p) begin
            col = 8'($urandom_range(w - 1)) - shadow_place_x;
            prow = 8'($urandom_range(p - 1 - lift));
          end
          send_request(pbb_pkg::FUNC_BLIT, pix, col, prow, raddr);
        end else if (roll < 85) begin
          if (w * p > 0 && $urandom_range(3) != 0) raddr = 10'($urandom_range(w * p - 1));
          send_request(pbb_pkg::FUNC_READ, pix, col, prow, raddr);
        end else begin
          send_request(($urandom_range(1) == 1) ? pbb_pkg::FUNC_READ : pbb_pkg::FUNC_BLIT,
                       pix, col, prow, raddr);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(13, 65, 142);
    test_random_traffic(65, 13, 142);
    test_random_traffic(0, 0, 142);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- page_bitmap_blit_unit.f -----
src/pbb_pkg.sv
src/pbb_ram.sv
src/pbb_front.sv
src/pbb_back.sv
src/page_bitmap_blit_unit.sv
src/pbb_checker.sv
dv/page_bitmap_blit_unit_tb.sv
